FILE: design/pbfr_pkg.sv
`timescale 1ns / 1ps
package pbfr_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_VERTICES_DEF = 4096;
  localparam int Q_FRAC = 16;
  localparam int SCORE_W = 17;
  localparam int TWICE_W = 34;
endpackage

FILE: design/pbfr_front.sv
`timescale 1ns / 1ps
module pbfr_front #(
  parameter int COORD_BITS = pbfr_pkg::COORD_BITS_DEF,
  parameter int MAX_VERTICES = pbfr_pkg::MAX_VERTICES_DEF,
  localparam int SUM_W = 2 * COORD_BITS + 13,
  localparam int BND_W = COORD_BITS + 1,
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic                         last,
  // closing hand-off
  output logic                         poly_valid,
  input  logic                         poly_take,
  output logic signed [SUM_W-1:0]      poly_sum,
  output logic [BND_W:0]               poly_rng [4],
  output logic                         poly_few
);
  import pbfr_pkg::*;

  logic signed [COORD_BITS-1:0] fx_r, fy_r, px_r, py_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [BND_W-1:0]      mn_r [4];
  logic signed [BND_W-1:0]      mx_r [4];
  logic [CNT_W-1:0]             cnt_r;
  // closing stage: second-stage products registered
  logic                         cl_r;
  logic signed [SUM_W-1:0]      cl_sum_r;
  logic signed [2*COORD_BITS:0] cl_a_r, cl_b_r;
  logic                         hold_r;
  logic signed [SUM_W-1:0]      h_sum_r;
  logic [BND_W:0]               h_rng_r [4];
  logic                         h_few_r;

  logic take;
  logic use_v;
  logic signed [BND_W-1:0] v [4];
  logic signed [2*COORD_BITS:0] p1, p2;
  logic signed [SUM_W-1:0] sum_nxt;
  localparam logic signed [BND_W-1:0] BHI = {1'b0, {(BND_W-1){1'b1}}};
  localparam logic signed [BND_W-1:0] BLO = {1'b1, {(BND_W-1){1'b0}}};

  assign full = cl_r || hold_r;
  assign take = push && !full;
  assign use_v = cnt_r < CNT_W'(MAX_VERTICES);

  always_comb begin
    v[0] = BND_W'(vx);
    v[1] = BND_W'(vy);
    v[2] = BND_W'(vx) - BND_W'(vy);
    v[3] = BND_W'(vx) + BND_W'(vy);
    p1 = (2*COORD_BITS+1)'(px_r * vy);
    p2 = (2*COORD_BITS+1)'(vx * py_r);
    sum_nxt = sum_r;
    if (use_v && cnt_r != '0) sum_nxt = sum_r + SUM_W'(p1) - SUM_W'(p2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; sum_r <= '0; cl_r <= 1'b0; hold_r <= 1'b0;
      fx_r <= '0; fy_r <= '0; px_r <= '0; py_r <= '0;
      for (int i = 0; i < 4; i++) begin
        mn_r[i] <= BHI; mx_r[i] <= BLO;
      end
    end else begin
      if (take) begin
        if (use_v) begin
          if (cnt_r == '0) begin
            fx_r <= vx; fy_r <= vy;
          end
          px_r <= vx; py_r <= vy;
          for (int i = 0; i < 4; i++) begin
            if (v[i] < mn_r[i]) mn_r[i] <= v[i];
            if (v[i] > mx_r[i]) mx_r[i] <= v[i];
          end
          cnt_r <= cnt_r + 1'b1;
        end
        sum_r <= sum_nxt;
        if (last) cl_r <= 1'b1;
      end
      if (cl_r) begin
        cl_r <= 1'b0;
        hold_r <= 1'b1;
        h_sum_r <= cl_sum_r + SUM_W'(cl_a_r) - SUM_W'(cl_b_r);
        for (int i = 0; i < 4; i++) h_rng_r[i] <= (BND_W+1)'(mx_r[i]) - (BND_W+1)'(mn_r[i]);
        h_few_r <= cnt_r < CNT_W'(3);
        cnt_r <= '0; sum_r <= '0;
        fx_r <= '0; fy_r <= '0; px_r <= '0; py_r <= '0;
        for (int i = 0; i < 4; i++) begin
          mn_r[i] <= BHI; mx_r[i] <= BLO;
        end
      end
      if (hold_r && poly_take) hold_r <= 1'b0;
    end
  end

  // closing products use the vertex state as it stands after the last beat
  always_ff @(posedge clk) begin
    if (take && last) cl_sum_r <= sum_nxt;
    if (take && last) begin
      cl_a_r <= (2*COORD_BITS+1)'((use_v ? vx : px_r) *
                                  ((use_v && cnt_r == '0) ? vy : fy_r));
      cl_b_r <= (2*COORD_BITS+1)'(((use_v && cnt_r == '0) ? vx : fx_r) *
                                  (use_v ? vy : py_r));
    end
  end

  assign poly_valid = hold_r;
  assign poly_sum = h_sum_r;
  assign poly_rng = h_rng_r;
  assign poly_few = h_few_r;
endmodule

FILE: design/pbfr_back.sv
`timescale 1ns / 1ps
module pbfr_back #(
  parameter int COORD_BITS = pbfr_pkg::COORD_BITS_DEF,
  localparam int SUM_W = 2 * COORD_BITS + 13,
  localparam int BND_W = COORD_BITS + 1,
  localparam int TW = 2 * COORD_BITS + 2,
  localparam int DW = 2 * BND_W + 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     poly_valid,
  output logic                     poly_take,
  input  logic signed [SUM_W-1:0]  poly_sum,
  input  logic [BND_W:0]           poly_rng [4],
  input  logic                     poly_few,
  output logic                     empty,
  input  logic                     pop,
  output logic [pbfr_pkg::SCORE_W-1:0] score,
  output logic [pbfr_pkg::TWICE_W-1:0] twice,
  output logic                     degen
);
  import pbfr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_D0 = 3'd2, S_D1 = 3'd3,
                         S_OUT = 3'd4;
  localparam logic [TW-1:0] TMAX = TW'(1) << (2*COORD_BITS+1);
  logic [2:0] st_r;
  logic [TW-1:0] t_r;
  logic [DW-1:0] b0_r, b45_r, den_r, rem_r;
  logic [Q_FRAC:0] q_r, r0_r;
  logic [4:0] it_r;
  logic few_r;
  logic [SUM_W-1:0] s_abs;
  logic [DW:0] r2;

  assign poly_take = st_r == S_IDLE && poly_valid;
  assign empty = st_r != S_OUT;
  // magnitude kept unsigned so the most negative sum still saturates
  assign s_abs = poly_sum[SUM_W-1] ? SUM_W'(-poly_sum) : SUM_W'(poly_sum);
  assign r2 = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (poly_valid) begin
          t_r <= (s_abs > SUM_W'(TMAX)) ? TMAX : TW'(s_abs);
          b0_r <= DW'(poly_rng[0] * poly_rng[1]);
          b45_r <= DW'(poly_rng[2] * poly_rng[3]);
          few_r <= poly_few;
          st_r <= S_MUL;
        end
        S_MUL: begin
          degen <= few_r || b0_r == '0 || b45_r == '0;
          twice <= TWICE_W'(t_r);
          den_r <= b0_r << 1;
          rem_r <= DW'(t_r);
          q_r <= '0; it_r <= '0;
          st_r <= (few_r || b0_r == '0 || b45_r == '0) ? S_OUT : S_D0;
          if (few_r || b0_r == '0 || b45_r == '0) score <= '0;
        end
        S_D0, S_D1: begin
          if (it_r == '0 && DW'(t_r) >= den_r) begin
            q_r <= (Q_FRAC+1)'(1) << Q_FRAC;
            it_r <= 5'd16;
          end else if (it_r != 5'd16) begin
            if (r2 >= {1'b0, den_r}) begin
              rem_r <= DW'(r2 - {1'b0, den_r});
              q_r <= {q_r[Q_FRAC-1:0], 1'b1};
            end else begin
              rem_r <= DW'(r2);
              q_r <= {q_r[Q_FRAC-1:0], 1'b0};
            end
            it_r <= it_r + 1'b1;
          end else if (st_r == S_D0) begin
            r0_r <= q_r;
            den_r <= b45_r; rem_r <= DW'(t_r); q_r <= '0; it_r <= '0;
            st_r <= S_D1;
          end else begin
            score <= SCORE_W'(({1'b0, r0_r} + {1'b0, q_r}) >> 1);
            st_r <= S_OUT;
          end
        end
        S_OUT: if (pop) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/polygon_box_fill_ratio.sv
`timescale 1ns / 1ps
// Polygon box fill ratio.
// Input channel: push/full with in_vertex_x, in_vertex_y, in_last_vertex.
// One vertex beat per cycle while full is low; the beat flagged last closes the polygon.
// Result channel: empty/pop with out_fill_score (Q16), out_twice_area and
// out_degenerate; one result beat per polygon.
// The front end accumulates shoelace sum and eight extent bounds per beat.
// After a last beat it closes the polygon in the cl_r stage (full high),
// then hands a record to the back end through a one-entry hold register.
// The back end forms both box areas and runs two 16-step
// restoring divisions, one per box, before the result is ready.
// A new polygon streams into the front end while the back end divides.
// When the receiver does not pop, the result waits, the hold register
// fills, and full stays high until space frees.
// Synchronous active-low reset clears all accumulators and empties both.
module polygon_box_fill_ratio #(
  parameter int COORD_BITS = pbfr_pkg::COORD_BITS_DEF,
  parameter int MAX_VERTICES = pbfr_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic signed [COORD_BITS-1:0]    in_vertex_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex_y,
  input  logic                            in_last_vertex,
  output logic                            empty,
  input  logic                            pop,
  output logic [pbfr_pkg::SCORE_W-1:0]    out_fill_score,
  output logic [pbfr_pkg::TWICE_W-1:0]    out_twice_area,
  output logic                            out_degenerate
);
  import pbfr_pkg::*;
  localparam int SUM_W = 2 * COORD_BITS + 13;
  localparam int BND_W = COORD_BITS + 1;

  logic poly_valid, poly_take, poly_few;
  logic signed [SUM_W-1:0] poly_sum;
  logic [BND_W:0] poly_rng [4];

  pbfr_front #(.COORD_BITS(COORD_BITS), .MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk, .rst_n, .push, .full,
    .vx(in_vertex_x), .vy(in_vertex_y), .last(in_last_vertex),
    .poly_valid, .poly_take, .poly_sum, .poly_rng, .poly_few
  );

  pbfr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst_n, .poly_valid, .poly_take, .poly_sum, .poly_rng, .poly_few,
    .empty, .pop,
    .score(out_fill_score), .twice(out_twice_area), .degen(out_degenerate)
  );
endmodule

FILE: verif/polygon_box_fill_ratio_test.sv
`timescale 1ns / 1ps
module polygon_box_fill_ratio_test;
  import pbfr_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int STALL_LIMIT = 4000;   // idle cycles with no beat on either side
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 60;    // extra wait once all results are in

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [TWICE_W-1:0] twice;
    logic               degen;
  } fill_result_t;

  // Tracks one polygon at a time and queues the result each closing beat
  // should produce.
  class fill_ratio_board;
    fill_result_t  due_q[$];
    longint        fx, fy, px, py;
    logic [44:0]   area_acc;          // wraps like the hardware sum
    longint        ext_lo[4], ext_hi[4];
    int            nverts;
    int            errors, checked, degen_seen;

    function new();
      clear_poly();
    endfunction

    function void clear_poly();
      fx = 0; fy = 0; px = 0; py = 0;
      area_acc = '0;
      nverts = 0;
      for (int i = 0; i < 4; i++) begin
        ext_lo[i] = 65535;
        ext_hi[i] = -65536;
      end
    endfunction

    // floor(2^16 * num / den), clamped at one
    function longint q16_ratio(longint num, longint den);
      if (num >= den) return 65536;
      return (num << Q_FRAC) / den;
    endfunction

    function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy, bit last);
      longint x, y, s, twice, b0, b45;
      longint v[4], rng[4];
      fill_result_t r;
      x = vx;
      y = vy;
      if (nverts < MAX_VERTICES_DEF) begin
        if (nverts == 0) begin
          fx = x; fy = y;
        end else begin
          area_acc = area_acc + 45'(px * y - x * py);
        end
        px = x; py = y;
        v[0] = x; v[1] = y; v[2] = x - y; v[3] = x + y;
        for (int i = 0; i < 4; i++) begin
          if (v[i] < ext_lo[i]) ext_lo[i] = v[i];
          if (v[i] > ext_hi[i]) ext_hi[i] = v[i];
        end
        nverts++;
      end
      if (!last) return;
      // closing edge back to the first vertex
      area_acc = area_acc + 45'(px * fy - fx * py);
      s = longint'($signed(area_acc));
      twice = (s < 0) ? -s : s;
      if (twice > (longint'(1) << 33)) twice = longint'(1) << 33;
      for (int i = 0; i < 4; i++) rng[i] = ext_hi[i] - ext_lo[i];
      b0 = rng[0] * rng[1];
      b45 = rng[2] * rng[3];
      r.degen = (nverts < 3) || (b0 == 0) || (b45 == 0);
      r.score = r.degen ? '0 : SCORE_W'((q16_ratio(twice, 2 * b0) + q16_ratio(twice, b45)) >> 1);
      r.twice = TWICE_W'(twice);
      due_q.push_back(r);
      clear_poly();
    endfunction

    function void check_result(logic [SCORE_W-1:0] score, logic [TWICE_W-1:0] twice,
                               logic degen);
      fill_result_t e;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result beat with nothing due: score %0d twice %0d degen %0b",
                   score, twice, degen);
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (e.degen) degen_seen++;
      if (score !== e.score || twice !== e.twice || degen !== e.degen) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: exp score %0d twice %0d degen %0b, got %0d %0d %0b",
                   checked, e.score, e.twice, e.degen, score, twice, degen);
      end
    endfunction
  endclass

  logic                 clk, rst_n, push, full, empty, pop;
  logic signed [15:0]   in_vertex_x, in_vertex_y;
  logic                 in_last_vertex;
  logic [SCORE_W-1:0]   out_fill_score;
  logic [TWICE_W-1:0]   out_twice_area;
  logic                 out_degenerate;

  fill_ratio_board board;
  int  vertex_beats, polygons, burst_left, idle_cycles;
  bit  hold_req;                      // asks the receiver for a long hold-off
  logic signed [15:0] px_q[$], py_q[$];

  polygon_box_fill_ratio u_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_last_vertex(in_last_vertex),
    .empty(empty), .pop(pop),
    .out_fill_score(out_fill_score), .out_twice_area(out_twice_area),
    .out_degenerate(out_degenerate)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Result monitor: values read just after the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      board.check_result(out_fill_score, out_twice_area, out_degenerate);
  end

  // Watchdog on cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("polygon_box_fill_ratio verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall pattern is redrawn from four modes; always-pop stretches too.
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && rst_n) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= $urandom_range(0, 1);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // One vertex beat; returns once it has been taken.
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
    push <= 1'b1;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_last_vertex <= last;
    do @(posedge clk); while (full);
    board.note_vertex(x, y, last);
    vertex_beats++;
    if (last) polygons++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // end of burst: random gap, then a new burst length
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end
  endtask

  // Sends the queued vertices as one polygon, flag on the final one.
  task automatic send_polygon();
    for (int i = 0; i < px_q.size(); i++)
      send_vertex(px_q[i], py_q[i], i == px_q.size() - 1);
    px_q.delete();
    py_q.delete();
  endtask

  task automatic add_pt(int x, int y);
    px_q.push_back(16'(x));
    py_q.push_back(16'(y));
  endtask

  // Random polygon inside a box of the given span.
  task automatic random_polygon(int nv, int span);
    int bx, by;
    bx = $urandom_range(0, 65535 - span) - 32768;
    by = $urandom_range(0, 65535 - span) - 32768;
    case ($urandom_range(0, 3))
      0: begin  // rectangle, corners in order
        add_pt(bx, by); add_pt(bx + span, by);
        add_pt(bx + span, by + span); add_pt(bx, by + span);
      end
      1: begin  // diamond
        add_pt(bx + span / 2, by); add_pt(bx + span, by + span / 2);
        add_pt(bx + span / 2, by + span); add_pt(bx, by + span / 2);
      end
      default: begin  // scattered points, may self-cross
        for (int i = 0; i < nv; i++)
          add_pt(bx + $urandom_range(0, span), by + $urandom_range(0, span));
      end
    endcase
    send_polygon();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int span, nv;
    board = new();
    vertex_beats = 0;
    polygons = 0;
    burst_left = 20;
    idle_cycles = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_vertex_x <= '0;
    in_vertex_y <= '0;
    in_last_vertex <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone vertex, two vertices, collinear triangle.
    add_pt(5, -7); send_polygon();
    add_pt(-32768, 32767); add_pt(32767, -32768); send_polygon();
    add_pt(0, 0); add_pt(10, 10); add_pt(20, 20); send_polygon();
    // Full-range square: both coordinate extremes.
    add_pt(-32768, -32768); add_pt(32767, -32768);
    add_pt(32767, 32767); add_pt(-32768, 32767); send_polygon();
    // Diamond: fills the diagonal box exactly.
    add_pt(0, -100); add_pt(100, 0); add_pt(0, 100); add_pt(-100, 0); send_polygon();
    // Full-range square wound twice: area saturates, ratios clamp.
    for (int k = 0; k < 2; k++) begin
      add_pt(-32768, -32768); add_pt(32767, -32768);
      add_pt(32767, 32767); add_pt(-32768, 32767);
    end
    send_polygon();
    // Directed part done: let it drain so the pause is covered.
    wait_drained();

    // Random polygons, mostly small sizes.
    while (vertex_beats < 545) begin
      if (polygons == 40) begin
        // receiver holds off while vertices keep coming: block fills, full rises
        hold_req = 1'b1;
      end
      if (polygons == 70) wait_drained();
      case ($urandom_range(0, 9))
        0: span = $urandom_range(0, 3);
        1, 2: span = 65535;
        default: span = $urandom_range(1, 4000);
      endcase
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      random_polygon(nv, span);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.due_q.size() != 0) begin
      board.errors++;
      $display("ERROR: %0d results never arrived", board.due_q.size());
    end
    $display("Covered %0d vertex beats in %0d polygons; %0d results checked, %0d degenerate.",
             vertex_beats, polygons, board.checked, board.degen_seen);
    $display("Mismatches: %0d", board.errors);
    if (board.errors == 0) begin
      $display("polygon_box_fill_ratio verification clean");
    end else begin
      $display("polygon_box_fill_ratio verification failed");
    end
    $finish;
  end

endmodule

FILE: polygon_box_fill_ratio.f
design/pbfr_pkg.sv
design/pbfr_front.sv
design/pbfr_back.sv
design/polygon_box_fill_ratio.sv
verif/polygon_box_fill_ratio_test.sv
